@@ rtl/ita_pkg.sv @@
// shared types, character codes and helpers for the integer to ascii formatter
// no dependencies; imported by every module of the block
package ita_pkg;

   // base select codes
   localparam logic [1:0] BASE_BIN = 2'd0;
   localparam logic [1:0] BASE_OCT = 2'd1;
   localparam logic [1:0] BASE_DEC = 2'd2;
   localparam logic [1:0] BASE_HEX = 2'd3;

   // ascii characters
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_B = 8'h62;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_NONE    = 8'h00;

   // field limits
   localparam logic [7:0] MAX_WIDTH = 8'd64;
   localparam logic [7:0] MAX_PREC  = 8'd62;

   // divide by ten: q = (v * RECIP10) >> RECIP10_SHIFT, exact for any 32-bit v
   localparam logic [31:0] RECIP10       = 32'hcccc_cccd;
   localparam int          RECIP10_SHIFT = 35;
   localparam int          QUO_W         = 64 - RECIP10_SHIFT;

   // job queue between front and back, depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_CONV,
      FS_PUSH
   } ita_front_state_type;

   typedef struct packed {
      logic [31:0] magnitude;
      logic        negative;
      logic [1:0]  base_select;
      logic        left_align;
      logic        zero_pad;
      logic        plus_sign;
      logic        space_sign;
      logic        alt_form;
      logic        precision_given;
      logic [5:0]  precision;
      logic [6:0]  width;
      logic        upper_case;
   } ita_req_type;

   // segment lengths of one formatted item, prefix first character in the top byte
   typedef struct packed {
      logic [6:0]  n_lead;
      logic [1:0]  n_prefix;
      logic [15:0] prefix;
      logic [6:0]  n_zero;
      logic [5:0]  n_digit;
      logic [6:0]  n_trail;
      logic [6:0]  total;
      logic        upper;
   } ita_job_type;

   localparam int JOB_W = $bits(ita_job_type);

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] alpha;
      alpha = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d < 4'd10) begin
         return CHAR_ZERO + {4'h0, d};
      end else begin
         return alpha + {4'h0, d} - 8'd10;
      end
   endfunction

endpackage

@@ rtl/ita_front.sv @@
// front end: takes a request, converts the value to digits one per cycle
// and works out the segment lengths; depends on ita_pkg
module ita_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  ita_pkg::ita_req_type     req,
   output logic                     req_full,
   input  logic                     q_full,
   output logic                     q_push,
   output ita_pkg::ita_job_type     q_job,
   output logic [4*VALUE_BITS-1:0]  q_digits
);
   import ita_pkg::*;

   localparam int DIG_W = 4 * VALUE_BITS;
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   ita_front_state_type state_ff, state_in;
   ita_req_type         req_ff;
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic [DIG_W-1:0]      digits_ff;
   logic [CNT_W-1:0]      nd_ff;

   logic [63:0]       prod;
   logic [QUO_W-1:0]  quo;
   logic [31:0]       rem;
   logic [3:0]        digit;

   logic       nonzero, zpe, is_dec, has_sign;
   logic [7:0] w8, p8, nd8, np8, body8, need8, pad8, lead8, zero8, trail8, total8;
   logic [15:0] prefix;

   // one digit per cycle, least significant first
   always_comb begin
      prod = 64'(v_ff) * 64'(RECIP10);
      quo  = prod[63:RECIP10_SHIFT];
      rem  = 32'(v_ff) - (32'(quo) * 32'd10);
      unique case (req_ff.base_select)
         BASE_BIN: begin
            digit = {3'b000, v_ff[0]};
            v_in  = v_ff >> 1;
         end
         BASE_OCT: begin
            digit = {1'b0, v_ff[2:0]};
            v_in  = v_ff >> 3;
         end
         BASE_DEC: begin
            digit = rem[3:0];
            v_in  = VALUE_BITS'(quo);
         end
         default: begin
            digit = v_ff[3:0];
            v_in  = v_ff >> 4;
         end
      endcase
   end

   // segment lengths, used in the push state
   always_comb begin
      nonzero  = req_ff.magnitude[VALUE_BITS-1:0] != '0;
      is_dec   = req_ff.base_select == BASE_DEC;
      zpe      = req_ff.zero_pad && !req_ff.precision_given && !req_ff.left_align;
      w8       = ({1'b0, req_ff.width} > MAX_WIDTH) ? MAX_WIDTH : {1'b0, req_ff.width};
      p8       = !req_ff.precision_given ? 8'd0 :
                 (({2'b00, req_ff.precision} > MAX_PREC) ? MAX_PREC :
                  {2'b00, req_ff.precision});
      // lone zero digit unless a precision is given
      nd8      = (nd_ff == '0 && !req_ff.precision_given) ? 8'd1 : 8'(nd_ff);
      has_sign = (nonzero && req_ff.negative) || req_ff.plus_sign || req_ff.space_sign;
      np8      = 8'd0;
      prefix   = {CHAR_NONE, CHAR_NONE};
      if (is_dec) begin
         if (has_sign) begin
            np8 = 8'd1;
         end
         priority if (nonzero && req_ff.negative) begin
            prefix = {CHAR_MINUS, CHAR_NONE};
         end else if (req_ff.plus_sign) begin
            prefix = {CHAR_PLUS, CHAR_NONE};
         end else begin
            prefix = {CHAR_SPACE, CHAR_NONE};
         end
      end else if (req_ff.alt_form && nonzero) begin
         unique case (req_ff.base_select)
            BASE_OCT: begin
               np8    = 8'd1;
               prefix = {CHAR_ZERO, CHAR_NONE};
            end
            BASE_BIN: begin
               np8    = 8'd2;
               prefix = {CHAR_ZERO, CHAR_LOWER_B};
            end
            default: begin
               np8    = 8'd2;
               prefix = {CHAR_ZERO, req_ff.upper_case ? CHAR_UPPER_X : CHAR_LOWER_X};
            end
         endcase
      end
      body8  = (p8 > nd8) ? p8 : nd8;
      need8  = body8 + np8;
      pad8   = (w8 > need8) ? (w8 - need8) : 8'd0;
      lead8  = (!req_ff.left_align && !zpe) ? pad8 : 8'd0;
      trail8 = req_ff.left_align ? pad8 : 8'd0;
      if (zpe) begin
         zero8 = (w8 > (nd8 + np8)) ? (w8 - nd8 - np8) : 8'd0;
      end else begin
         zero8 = (p8 > nd8) ? (p8 - nd8) : 8'd0;
      end
      total8 = lead8 + np8 + zero8 + nd8 + trail8;

      q_job.n_lead   = lead8[6:0];
      q_job.n_prefix = np8[1:0];
      q_job.prefix   = prefix;
      q_job.n_zero   = zero8[6:0];
      q_job.n_digit  = nd8[5:0];
      q_job.n_trail  = trail8[6:0];
      q_job.total    = total8[6:0];
      q_job.upper    = req_ff.upper_case;
   end

   assign q_digits = digits_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_IDLE: begin
            if (req_push) begin
               state_in = FS_CONV;
            end
         end
         FS_CONV: begin
            if (v_ff == '0) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            // an empty run is dropped
            if (q_job.total == '0 || !q_full) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   always_comb begin
      req_full = state_ff != FS_IDLE;
      q_push   = (state_ff == FS_PUSH) && !q_full && (q_job.total != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == FS_IDLE && req_push) begin
         req_ff    <= req;
         v_ff      <= req.magnitude[VALUE_BITS-1:0];
         digits_ff <= '0;
         nd_ff     <= '0;
      end else if (state_ff == FS_CONV && v_ff != '0) begin
         // new digit enters at the top, so the most significant ends up there
         v_ff      <= v_in;
         digits_ff <= {digit, digits_ff[DIG_W-1:4]};
         nd_ff     <= nd_ff + CNT_W'(1);
      end
   end

`ifndef SYNTHESIS
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff != FS_IDLE |-> nd_ff <= CNT_W'(VALUE_BITS))
      else $error("digit count beyond value width");
`endif

endmodule

@@ rtl/ita_fifo.sv @@
// short job queue between front and back end
// depends on ita_pkg for the depth constants
module ita_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   import ita_pkg::*;

   logic [WIDTH-1:0]       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("job popped from empty queue");
`endif

endmodule

@@ rtl/ita_back.sv @@
// back end: walks the segments of one job and sends one character per cycle
// while the consumer keeps popping, through a single output register; depends on ita_pkg
module ita_back #(
   parameter int VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  ita_pkg::ita_job_type     q_job,
   input  logic [4*VALUE_BITS-1:0]  q_digits,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [7:0]               rsp_character,
   output logic                     rsp_last
);
   import ita_pkg::*;

   localparam int DIG_W = 4 * VALUE_BITS;

   logic             busy_ff, busy_in;
   logic [6:0]       remain_ff, remain_in;
   logic [6:0]       lead_ff, lead_in;
   logic [1:0]       npre_ff, npre_in;
   logic [15:0]      pre_ff, pre_in;
   logic [6:0]       zero_ff, zero_in;
   logic [5:0]       ndig_ff, ndig_in;
   logic [6:0]       trail_ff, trail_in;
   logic             upper_ff, upper_in;
   logic [DIG_W-1:0] digits_ff, digits_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_char_ff;
   logic             out_last_ff;

   logic       emit, load;
   logic [7:0] char_sel;
   logic [7:0] seg_sum;

   assign emit  = busy_ff && (!out_valid_ff || rsp_pop);
   assign load  = !busy_ff && !q_empty;
   assign q_pop = load;

   always_comb begin
      busy_in   = busy_ff;
      remain_in = remain_ff;
      lead_in   = lead_ff;
      npre_in   = npre_ff;
      pre_in    = pre_ff;
      zero_in   = zero_ff;
      ndig_in   = ndig_ff;
      trail_in  = trail_ff;
      upper_in  = upper_ff;
      digits_in = digits_ff;
      char_sel  = CHAR_SPACE;
      if (load) begin
         busy_in   = 1'b1;
         remain_in = q_job.total;
         lead_in   = q_job.n_lead;
         npre_in   = q_job.n_prefix;
         pre_in    = q_job.prefix;
         zero_in   = q_job.n_zero;
         ndig_in   = q_job.n_digit;
         trail_in  = q_job.n_trail;
         upper_in  = q_job.upper;
         digits_in = q_digits;
      end else if (emit) begin
         remain_in = remain_ff - 7'd1;
         busy_in   = remain_ff != 7'd1;
         priority if (lead_ff != '0) begin
            lead_in = lead_ff - 7'd1;
         end else if (npre_ff != '0) begin
            char_sel = pre_ff[15:8];
            pre_in   = {pre_ff[7:0], CHAR_NONE};
            npre_in  = npre_ff - 2'd1;
         end else if (zero_ff != '0) begin
            char_sel = CHAR_ZERO;
            zero_in  = zero_ff - 7'd1;
         end else if (ndig_ff != '0) begin
            char_sel  = digit_char(digits_ff[DIG_W-1 -: 4], upper_ff);
            digits_in = {digits_ff[DIG_W-5:0], 4'h0};
            ndig_in   = ndig_ff - 6'd1;
         end else if (trail_ff != '0) begin
            trail_in = trail_ff - 7'd1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_last      = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_ff   <= lead_in;
      npre_ff   <= npre_in;
      pre_ff    <= pre_in;
      zero_ff   <= zero_in;
      ndig_ff   <= ndig_in;
      trail_ff  <= trail_in;
      upper_ff  <= upper_in;
      digits_ff <= digits_in;
      if (emit) begin
         out_char_ff <= char_sel;
         out_last_ff <= remain_ff == 7'd1;
      end
   end

   assign seg_sum = 8'(lead_ff) + 8'(npre_ff) + 8'(zero_ff) + 8'(ndig_ff) + 8'(trail_ff);

`ifndef SYNTHESIS
   a_remain_matches: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> seg_sum == 8'(remain_ff))
      else $error("remaining count out of step with segment counters");
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> remain_ff == '0)
      else $error("back end idle with characters left");
   a_open_run: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> busy_ff)
      else $error("non-final item waiting but run already closed");
`endif

endmodule

@@ rtl/integer_to_padded_ascii.sv @@
// top level of the integer to ascii formatter
// depends on ita_pkg, ita_front, ita_fifo and ita_back
//
// Formats one integer request (magnitude, sign, base 2/8/10/16, flags, width and
// precision) into ascii characters, one item per character on the rsp side, with
// rsp_last on the final one; a request that formats to nothing gives no item.
// The front end takes a request, converts one digit per cycle (the digit loop
// divides by the base, a reciprocal multiply for decimal), sees the value run out
// and then hands the job over while the job queue has room. The back end then
// loads a job and sends one character per cycle, up to 64, at the rate the
// consumer pops. A two-entry job queue lets the front convert the next request
// while the back end is still sending, so the sustained rate is set by the
// slower of the two.
module integer_to_padded_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_magnitude,
   input  logic        req_negative,
   input  logic [1:0]  req_base_select,
   input  logic        req_left_align,
   input  logic        req_zero_pad,
   input  logic        req_plus_sign,
   input  logic        req_space_sign,
   input  logic        req_alt_form,
   input  logic        req_precision_given,
   input  logic [5:0]  req_precision,
   input  logic [6:0]  req_width,
   input  logic        req_upper_case,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);
   import ita_pkg::*;

   localparam int DIG_W   = 4 * VALUE_BITS;
   localparam int ENTRY_W = JOB_W + DIG_W;

   ita_req_type      req;
   ita_job_type      front_job, back_job;
   logic [DIG_W-1:0] front_digits, back_digits;
   logic             q_push, q_full, q_pop, q_empty;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;

   always_comb begin
      req.magnitude       = req_magnitude;
      req.negative        = req_negative;
      req.base_select     = req_base_select;
      req.left_align      = req_left_align;
      req.zero_pad        = req_zero_pad;
      req.plus_sign       = req_plus_sign;
      req.space_sign      = req_space_sign;
      req.alt_form        = req_alt_form;
      req.precision_given = req_precision_given;
      req.precision       = req_precision;
      req.width           = req_width;
      req.upper_case      = req_upper_case;
   end

   ita_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req      (req),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (front_job),
      .q_digits (front_digits)
   );

   assign q_wdata = {front_job, front_digits};
   assign {back_job, back_digits} = q_rdata;

   ita_fifo #(
      .WIDTH (ENTRY_W)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   ita_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_job         (back_job),
      .q_digits      (back_digits),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// self-checking bench for integer_to_padded_ascii: a directed table, then random requests
// depends on ita_pkg and the formatter rtl; every char item is checked against the table text or a predictor
module testbench;
   import ita_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 253;
   localparam int MAX_CHARS    = 64;

   // request flags used by the directed table
   localparam logic [7:0] F_NONE  = 8'h00;
   localparam logic [7:0] F_NEG   = 8'h01;
   localparam logic [7:0] F_LEFT  = 8'h02;
   localparam logic [7:0] F_ZERO  = 8'h04;
   localparam logic [7:0] F_PLUS  = 8'h08;
   localparam logic [7:0] F_SPACE = 8'h10;
   localparam logic [7:0] F_ALT   = 8'h20;
   localparam logic [7:0] F_PREC  = 8'h40;
   localparam logic [7:0] F_UPPER = 8'h80;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } char_item_type;

   typedef struct {
      logic [31:0] magnitude;
      logic [1:0]  base_select;
      logic [7:0]  flags;
      logic [5:0]  precision;
      logic [6:0]  width;
      bit          has_text;
      string       text;
   } direct_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_magnitude = '0;
   logic        req_negative = 1'b0;
   logic [1:0]  req_base_select = BASE_DEC;
   logic        req_left_align = 1'b0;
   logic        req_zero_pad = 1'b0;
   logic        req_plus_sign = 1'b0;
   logic        req_space_sign = 1'b0;
   logic        req_alt_form = 1'b0;
   logic        req_precision_given = 1'b0;
   logic [5:0]  req_precision = '0;
   logic [6:0]  req_width = '0;
   logic        req_upper_case = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_character;
   logic        rsp_last;

   char_item_type awaited_chars [$];
   int         mismatches = 0;
   bit         send_calm = 1'b0;
   bit         take_calm = 1'b0;

   // rows with has_text set carry the expected output, the rest go through the predictor
   direct_row_type direct_table [27] = '{
      '{32'd0,          BASE_DEC, F_NONE,           6'd0,  7'd0,   1'b1, "0"},
      '{32'd0,          BASE_DEC, F_PREC,           6'd0,  7'd0,   1'b1, ""},
      '{32'hffff_ffff,  BASE_HEX, F_ALT | F_UPPER,  6'd0,  7'd0,   1'b1, "0XFFFFFFFF"},
      '{32'hffff_ffff,  BASE_DEC, F_NEG,            6'd0,  7'd0,   1'b1, "-4294967295"},
      '{32'hffff_ffff,  BASE_BIN, F_NONE,           6'd0,  7'd0,   1'b0, ""},
      '{32'hffff_ffff,  BASE_OCT, F_ALT,            6'd0,  7'd0,   1'b1, "037777777777"},
      '{32'd42,         BASE_DEC, F_PLUS,           6'd0,  7'd0,   1'b1, "+42"},
      '{32'd42,         BASE_DEC, F_SPACE,          6'd0,  7'd0,   1'b1, " 42"},
      '{32'd42,         BASE_DEC, F_PLUS | F_SPACE, 6'd0,  7'd0,   1'b1, "+42"},
      '{32'd255,        BASE_HEX, F_NEG,            6'd0,  7'd0,   1'b1, "ff"},
      '{32'd42,         BASE_DEC, F_NONE,           6'd0,  7'd6,   1'b1, "    42"},
      '{32'd42,         BASE_DEC, F_LEFT,           6'd0,  7'd6,   1'b1, "42    "},
      '{32'd42,         BASE_DEC, F_NEG | F_ZERO,   6'd0,  7'd6,   1'b1, "-00042"},
      '{32'd42,         BASE_DEC, F_ZERO | F_PREC,  6'd3,  7'd6,   1'b1, "   042"},
      '{32'd42,         BASE_DEC, F_LEFT | F_ZERO,  6'd0,  7'd6,   1'b1, "42    "},
      '{32'd0,          BASE_HEX, F_ALT,            6'd0,  7'd0,   1'b1, "0"},
      '{32'd0,          BASE_DEC, F_NEG,            6'd0,  7'd0,   1'b1, "0"},
      '{32'd0,          BASE_DEC, F_PLUS | F_ZERO,  6'd0,  7'd1,   1'b1, "+0"},
      '{32'd12345,      BASE_DEC, F_NONE,           6'd0,  7'd127, 1'b0, ""},
      '{32'd7,          BASE_OCT, F_PREC,           6'd63, 7'd0,   1'b0, ""},
      '{32'hffff_ffff,  BASE_DEC, F_NEG | F_PREC,   6'd63, 7'd127, 1'b0, ""},
      '{32'd42,  BASE_DEC, F_LEFT | F_PLUS | F_PREC, 6'd63, 7'd127, 1'b0, ""},
      '{32'hffff_ffff,  BASE_BIN, F_ALT | F_ZERO,   6'd0,  7'd127, 1'b0, ""},
      '{32'd0,          BASE_DEC, F_PREC,           6'd0,  7'd5,   1'b1, "     "},
      '{32'd5,          BASE_BIN, F_ALT,            6'd0,  7'd0,   1'b1, "0b101"},
      '{32'habc,        BASE_HEX, F_ALT,            6'd0,  7'd0,   1'b1, "0xabc"},
      '{32'd0,          BASE_DEC, F_PLUS | F_PREC,  6'd0,  7'd0,   1'b1, "+"}
   };

   integer_to_padded_ascii dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_magnitude       (req_magnitude),
      .req_negative        (req_negative),
      .req_base_select     (req_base_select),
      .req_left_align      (req_left_align),
      .req_zero_pad        (req_zero_pad),
      .req_plus_sign       (req_plus_sign),
      .req_space_sign      (req_space_sign),
      .req_alt_form        (req_alt_form),
      .req_precision_given (req_precision_given),
      .req_precision       (req_precision),
      .req_width           (req_width),
      .req_upper_case      (req_upper_case),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_character       (rsp_character),
      .rsp_last            (rsp_last)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (mismatches < 100) begin
         $display("mismatch at %0t: %s", $time, what);
      end
      mismatches++;
   endtask

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 11));
   endfunction

   // formats one request and queues the char items it should produce
   function automatic void format_integer(input ita_req_type r);
      logic [7:0]  text [$];
      logic [3:0]  digits [$];
      logic [31:0] v;
      logic [31:0] radix;
      logic [7:0]  alpha;
      int          prec, wid, ndig, body, nextra, count;
      bit          nonzero, zero_fill;
      case (r.base_select)
         BASE_BIN: radix = 32'd2;
         BASE_OCT: radix = 32'd8;
         BASE_DEC: radix = 32'd10;
         default:  radix = 32'd16;
      endcase
      prec = r.precision_given ? int'(r.precision) : 0;
      if (prec > int'(MAX_PREC)) prec = int'(MAX_PREC);
      wid = int'(r.width);
      if (wid > int'(MAX_WIDTH)) wid = int'(MAX_WIDTH);
      v = r.magnitude;
      nonzero = (v != 0);
      while (v != 0) begin
         digits.push_front(4'(v % radix));
         v = v / radix;
      end
      // a lone zero digit unless a precision is given
      if (!nonzero && !r.precision_given) digits.push_back(4'd0);
      ndig = digits.size();
      zero_fill = r.zero_pad && !r.precision_given && !r.left_align;
      nextra = 0;
      if (r.base_select == BASE_DEC) begin
         if ((nonzero && r.negative) || r.plus_sign || r.space_sign) nextra = 1;
      end else if (r.alt_form && nonzero) begin
         nextra = (r.base_select == BASE_OCT) ? 1 : 2;
      end
      body = (prec > ndig) ? prec : ndig;
      if (!r.left_align && !zero_fill) begin
         for (int i = body + nextra; i < wid; i++) text.push_back(CHAR_SPACE);
      end
      if (r.base_select == BASE_DEC) begin
         if (nonzero && r.negative) text.push_back(CHAR_MINUS);
         else if (r.plus_sign) text.push_back(CHAR_PLUS);
         else if (r.space_sign) text.push_back(CHAR_SPACE);
      end else if (r.alt_form && nonzero) begin
         text.push_back(CHAR_ZERO);
         if (r.base_select == BASE_BIN) text.push_back(CHAR_LOWER_B);
         else if (r.base_select == BASE_HEX)
            text.push_back(r.upper_case ? CHAR_UPPER_X : CHAR_LOWER_X);
      end
      if (zero_fill) begin
         for (int i = ndig + nextra; i < wid; i++) text.push_back(CHAR_ZERO);
      end else begin
         for (int i = ndig; i < prec; i++) text.push_back(CHAR_ZERO);
      end
      alpha = r.upper_case ? CHAR_UPPER_A : CHAR_LOWER_A;
      foreach (digits[i]) begin
         if (digits[i] < 4'd10) text.push_back(CHAR_ZERO + {4'h0, digits[i]});
         else text.push_back(alpha + {4'h0, digits[i]} - 8'd10);
      end
      if (r.left_align) begin
         while (text.size() < wid) text.push_back(CHAR_SPACE);
      end
      count = (text.size() < MAX_CHARS) ? text.size() : MAX_CHARS;
      for (int i = 0; i < count; i++) awaited_chars.push_back('{text[i], i == count - 1});
   endfunction

   function automatic void expect_text(input string s);
      for (int i = 0; i < s.len(); i++) awaited_chars.push_back('{s[i], i == s.len() - 1});
   endfunction

   function automatic ita_req_type random_request();
      ita_req_type r;
      case ($urandom_range(0, 7))
         0:       r.magnitude = 32'd0;
         1:       r.magnitude = 32'hffff_ffff - $urandom_range(0, 3);
         default: r.magnitude = $urandom >> $urandom_range(0, 31);
      endcase
      r.negative        = 1'($urandom_range(0, 1));
      r.base_select     = 2'($urandom_range(0, 3));
      r.left_align      = 1'($urandom_range(0, 1));
      r.zero_pad        = 1'($urandom_range(0, 1));
      r.plus_sign       = 1'($urandom_range(0, 1));
      r.space_sign      = 1'($urandom_range(0, 1));
      r.alt_form        = 1'($urandom_range(0, 1));
      r.precision_given = 1'($urandom_range(0, 1));
      r.upper_case      = 1'($urandom_range(0, 1));
      // mostly short fields, now and then the full range up to saturation
      r.precision = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 10));
      r.width     = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 16));
      return r;
   endfunction

   task automatic send_request(input ita_req_type r, input bit has_text, input string text);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_magnitude       <= r.magnitude;
      req_negative        <= r.negative;
      req_base_select     <= r.base_select;
      req_left_align      <= r.left_align;
      req_zero_pad        <= r.zero_pad;
      req_plus_sign       <= r.plus_sign;
      req_space_sign      <= r.space_sign;
      req_alt_form        <= r.alt_form;
      req_precision_given <= r.precision_given;
      req_precision       <= r.precision;
      req_width           <= r.width;
      req_upper_case      <= r.upper_case;
      req_push            <= 1'b1;
      do @(posedge clock); while (req_full);
      if (has_text) expect_text(text);
      else format_integer(r);
      if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
   endtask

   initial begin : stimulus
      direct_row_type row;
      ita_req_type r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (direct_table[k]) begin
         row = direct_table[k];
         r.magnitude       = row.magnitude;
         r.base_select     = row.base_select;
         r.negative        = |(row.flags & F_NEG);
         r.left_align      = |(row.flags & F_LEFT);
         r.zero_pad        = |(row.flags & F_ZERO);
         r.plus_sign       = |(row.flags & F_PLUS);
         r.space_sign      = |(row.flags & F_SPACE);
         r.alt_form        = |(row.flags & F_ALT);
         r.precision_given = |(row.flags & F_PREC);
         r.upper_case      = |(row.flags & F_UPPER);
         r.precision       = row.precision;
         r.width           = row.width;
         send_request(r, row.has_text, row.text);
      end
      repeat (RANDOM_ITEMS) send_request(random_request(), 1'b0, "");
      req_push <= 1'b0;
      while (awaited_chars.size() != 0) @(posedge clock);
      // a request with no output may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : receiver
      int         gap;
      char_item_type want;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(take_calm);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (awaited_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected item char %h last %b",
                                      rsp_character, rsp_last));
         end else begin
            want = awaited_chars.pop_front();
            if (rsp_character !== want.character)
               report_mismatch($sformatf("char %h, expected %h",
                                         rsp_character, want.character));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, expected %b on char %h",
                                         rsp_last, want.last, want.character));
         end
         if ($urandom_range(0, 19) == 0) take_calm = !take_calm;
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
